// File: rtl/cciw_pkg.sv
package cciw_pkg;

    // Field widths fixed by the stream format.
    localparam int COORD_W   = 18;
    localparam int COEF_W    = 18;
    localparam int OUT_W     = 20;
    localparam int IDX_W     = 4;
    localparam int CFG_W     = 5;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 64;

    // Input tdata layout, lowest bit first.
    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = 4;
    localparam int COEF_LSB  = 8;
    localparam int PX_LSB    = 26;
    localparam int PY_LSB    = 44;
    localparam int PZ_LSB    = 62;

    // Datapath widths.
    localparam int ACC_W     = 45;
    localparam int LO_W      = 22;
    localparam int MULB_W    = 24;
    localparam int PROD_W    = COORD_W + MULB_W;
    localparam int WIDE_W    = 64;
    localparam int QUO_W     = 20;
    localparam int CNT_W     = 5;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [CFG_W-1:0] NODES_RESET = 5'd5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_RND,
        ST_UPD,
        ST_DIV_INIT,
        ST_DIV_CHK,
        ST_DIV,
        ST_SIGN,
        ST_OUT
    } seq_state_t;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_RND,
        OP_UPD,
        OP_DIV_INIT,
        OP_DIV_CHK,
        OP_DIV_STEP,
        OP_SIGN
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     fin;
    } lane_ctl_t;

endpackage

// File: rtl/chebyshev_interpolation_weights_unit.sv
// Chebyshev node weights for a 3-D point, by Clenshaw summation.
//
// Input stream: tuser selects the request. A load (tuser 0) writes one
// coefficient into the table at row coef_row, term coef_col. An evaluate
// (tuser 1) carries a point; tlast marks the last point of a batch. The
// output stream gives one transfer per node row, rows 0 to n-1, with the x,
// y and z weights; tlast is set on row n-1, tuser on row n-1 of a batch's
// last point. cfg_we writes the node count n.
//
// Every recurrence step runs through one multiplier per axis in two partial
// products plus accumulate, round and update; the scaling by 2/n is a
// bit-serial divider of 20 steps per row. The input is not ready while a
// point is in work, but a load or the next point is taken while the last row
// still waits in the output register.
//
// Reset clears the control state and sets n to 5; the coefficient table is
// not cleared and must be loaded before use. When the receiver stalls, the
// output holds its transfer and the next row waits after it is finished.
module chebyshev_interpolation_weights_unit #(
    parameter int MAX_NODES = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // coef_row, coef_col, coef_value, point_x, point_y, point_z
    input  logic [cciw_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // node_index, weight_x, weight_y, weight_z
    output logic [cciw_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // batch_end
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [cciw_pkg::CFG_W-1:0]      cfg_wdata
);
    import cciw_pkg::*;

    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int MW    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0]         num_nodes_reg;
    logic [NW-1:0]            n_eff;
    logic [NW-1:0]            n_cur;
    logic                     in_xfer;
    logic                     start;
    logic                     load_ok;
    logic [IDX_W-1:0]         coef_row;
    logic [IDX_W-1:0]         coef_col;
    logic signed [COEF_W-1:0] coef_value;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;

    logic signed [COEF_W-1:0]  coef_mem [DEPTH];
    logic signed [COEF_W-1:0]  coef_rd_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic                      fin_reg;

    logic                    ready;
    lane_ctl_t               ctl;
    logic [MW-1:0]           row_idx;
    logic [MW-1:0]           col_idx;
    logic                    out_load;
    logic                    out_last;
    logic                    out_busy;
    logic signed [OUT_W-1:0] wx, wy, wz;

    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg;
    logic                    m_last_reg;
    logic                    m_user_reg;

    assign coef_row   = s_axis_tdata[ROW_LSB +: IDX_W];
    assign coef_col   = s_axis_tdata[COL_LSB +: IDX_W];
    assign coef_value = $signed(s_axis_tdata[COEF_LSB +: COEF_W]);

    assign in_xfer = s_axis_tvalid && ready;
    assign start   = in_xfer && (s_axis_tuser == REQ_EVAL);
    assign load_ok = in_xfer && (s_axis_tuser == REQ_LOAD) &&
                     (int'(coef_row) < MAX_NODES) && (int'(coef_col) < MAX_NODES);
    assign wr_addr = AW'(int'(coef_row) * MAX_NODES + int'(coef_col));
    assign rd_addr = AW'(int'(row_idx) * MAX_NODES + int'(col_idx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_nodes_reg <= NODES_RESET;
        end
        else if (cfg_we)
        begin
            num_nodes_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (num_nodes_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(num_nodes_reg) > MAX_NODES)
        begin
            n_eff = NW'(MAX_NODES);
        end
        else
        begin
            n_eff = NW'(num_nodes_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            coef_mem[wr_addr] <= coef_value;
        end
        coef_rd_reg <= coef_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg  <= $signed(s_axis_tdata[PX_LSB +: COORD_W]);
            py_reg  <= $signed(s_axis_tdata[PY_LSB +: COORD_W]);
            pz_reg  <= $signed(s_axis_tdata[PZ_LSB +: COORD_W]);
            fin_reg <= s_axis_tlast;
        end
    end

    assign out_busy = m_valid_reg && !m_axis_tready;

    cciw_seq #(
        .NW (NW),
        .MW (MW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .n_eff    (n_eff),
        .out_busy (out_busy),
        .ready    (ready),
        .ctl      (ctl),
        .n_cur    (n_cur),
        .row      (row_idx),
        .col      (col_idx),
        .out_load (out_load),
        .out_last (out_last)
    );

    cciw_lane #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_lane_x (
        .clk    (clk),
        .ctl    (ctl),
        .coord  (px_reg),
        .coef   (coef_rd_reg),
        .n      (n_cur),
        .weight (wx)
    );

    cciw_lane #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_lane_y (
        .clk    (clk),
        .ctl    (ctl),
        .coord  (py_reg),
        .coef   (coef_rd_reg),
        .n      (n_cur),
        .weight (wy)
    );

    cciw_lane #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_lane_z (
        .clk    (clk),
        .ctl    (ctl),
        .coord  (pz_reg),
        .coef   (coef_rd_reg),
        .n      (n_cur),
        .weight (wz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {wz, wy, wx, IDX_W'(row_idx)};
            m_last_reg <= out_last;
            m_user_reg <= out_last && fin_reg;
        end
    end

    assign s_axis_tready = ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// File: rtl/cciw_lane.sv
module cciw_lane #(
    parameter int FRAC_BITS = 16,
    parameter int NW        = 5
) (
    input  logic                                clk,
    input  cciw_pkg::lane_ctl_t                 ctl,
    input  logic signed [cciw_pkg::COORD_W-1:0] coord,
    input  logic signed [cciw_pkg::COEF_W-1:0]  coef,
    input  logic [NW-1:0]                       n,
    output logic signed [cciw_pkg::OUT_W-1:0]   weight
);
    import cciw_pkg::*;

    localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) <<< (FRAC_BITS - 1);

    logic signed [ACC_W-1:0]  d0_reg;
    logic signed [ACC_W-1:0]  d1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] t_reg;
    logic [WIDE_W-1:0]        num_reg;
    logic [NW-1:0]            rem_reg;
    logic [QUO_W-1:0]         q_reg;
    logic                     neg_reg;
    logic                     clamp_reg;
    logic signed [OUT_W-1:0]  weight_reg;

    logic signed [MULB_W-1:0] mul_b;
    logic signed [WIDE_W-1:0] rnd_in;
    logic signed [WIDE_W-1:0] upd_sum;
    logic signed [WIDE_W-1:0] fin_sum;
    logic [WIDE_W-1:0]        mag;
    logic [NW:0]              rem_shift;
    logic                     rem_ge;

    // The 45-bit recurrence value is multiplied in two halves: the unsigned
    // low part first, then the signed high part, shifted into place.
    always_comb
    begin
        if (ctl.op == OP_MUL_HI)
        begin
            mul_b = {{(MULB_W-(ACC_W-LO_W)){d0_reg[ACC_W-1]}}, d0_reg[ACC_W-1:LO_W]};
        end
        else
        begin
            mul_b = {{(MULB_W-LO_W){1'b0}}, d0_reg[LO_W-1:0]};
        end
    end

    always_comb
    begin
        rnd_in    = ctl.fin ? acc_reg : (acc_reg <<< 1);
        upd_sum   = t_reg - WIDE_W'(d1_reg) + WIDE_W'(coef);
        fin_sum   = t_reg - WIDE_W'(d1_reg) + WIDE_W'(coef >>> 1);
        mag       = t_reg[WIDE_W-1] ? WIDE_W'(-t_reg) : WIDE_W'(t_reg);
        rem_shift = {rem_reg, q_reg[QUO_W-1]};
        rem_ge    = rem_shift >= {1'b0, n};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coord * mul_b;
        unique case (ctl.op)
            OP_CLEAR:
            begin
                d0_reg <= '0;
                d1_reg <= '0;
            end
            OP_MUL_HI:
            begin
                acc_reg <= WIDE_W'(prod_reg);
            end
            OP_ACC:
            begin
                acc_reg <= acc_reg + (WIDE_W'(prod_reg) <<< LO_W);
            end
            OP_RND:
            begin
                t_reg <= (rnd_in + HALF) >>> FRAC_BITS;
            end
            OP_UPD:
            begin
                if (ctl.fin)
                begin
                    t_reg <= fin_sum;
                end
                else
                begin
                    if (upd_sum > WIDE_W'(ACC_MAX))
                    begin
                        d0_reg <= ACC_MAX;
                    end
                    else if (upd_sum < WIDE_W'(ACC_MIN))
                    begin
                        d0_reg <= ACC_MIN;
                    end
                    else
                    begin
                        d0_reg <= upd_sum[ACC_W-1:0];
                    end
                    d1_reg <= d0_reg;
                end
            end
            OP_DIV_INIT:
            begin
                neg_reg <= t_reg[WIDE_W-1];
                num_reg <= (mag << 1) + WIDE_W'(n >> 1);
            end
            OP_DIV_CHK:
            begin
                // A quotient of 2^20 or more saturates anyway, so only the
                // low 20 quotient bits are ever formed.
                clamp_reg <= num_reg >= (WIDE_W'(n) << QUO_W);
                rem_reg   <= NW'(num_reg >> QUO_W);
                q_reg     <= num_reg[QUO_W-1:0];
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? NW'(rem_shift - {1'b0, n}) : NW'(rem_shift);
                q_reg   <= {q_reg[QUO_W-2:0], rem_ge};
            end
            OP_SIGN:
            begin
                if (clamp_reg)
                begin
                    weight_reg <= neg_reg ? OUT_MIN : OUT_MAX;
                end
                else if (neg_reg)
                begin
                    weight_reg <= (q_reg[QUO_W-1] && (|q_reg[QUO_W-2:0])) ?
                                  OUT_MIN : OUT_W'(-$signed({1'b0, q_reg}));
                end
                else
                begin
                    weight_reg <= q_reg[QUO_W-1] ? OUT_MAX : $signed(q_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign weight = weight_reg;

endmodule

// File: rtl/cciw_seq.sv
module cciw_seq #(
    parameter int NW = 5,
    parameter int MW = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NW-1:0]       n_eff,
    input  logic                out_busy,
    output logic                ready,
    output cciw_pkg::lane_ctl_t ctl,
    output logic [NW-1:0]       n_cur,
    output logic [MW-1:0]       row,
    output logic [MW-1:0]       col,
    output logic                out_load,
    output logic                out_last
);
    import cciw_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [MW-1:0]    m_reg, m_next;
    logic [MW-1:0]    j_reg, j_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             row_last;

    assign row_last = NW'(m_reg) == n_reg - NW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            m_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        ready      = 1'b0;
        out_load   = 1'b0;
        ctl.op     = OP_HOLD;
        ctl.fin    = j_reg == '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    n_next     = n_eff;
                    m_next     = '0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                ctl.op     = OP_CLEAR;
                j_next     = MW'(n_reg - NW'(1));
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                ctl.op     = OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                ctl.op     = OP_MUL_HI;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                ctl.op     = OP_ACC;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                ctl.op     = OP_RND;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ctl.op = OP_UPD;
                if (j_reg == '0)
                begin
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    j_next     = j_reg - MW'(1);
                    state_next = ST_MUL_LO;
                end
            end
            ST_DIV_INIT:
            begin
                ctl.op     = OP_DIV_INIT;
                state_next = ST_DIV_CHK;
            end
            ST_DIV_CHK:
            begin
                ctl.op     = OP_DIV_CHK;
                cnt_next   = CNT_W'(QUO_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                ctl.op     = OP_SIGN;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    out_load = 1'b1;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        m_next     = m_reg + MW'(1);
                        state_next = ST_ROW;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign n_cur    = n_reg;
    assign row      = m_reg;
    assign col      = j_reg;
    assign out_last = row_last;

endmodule

// File: rtl/cciw_checker.sv
module cciw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [cciw_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);
    import cciw_pkg::*;

    // A stalled output transfer keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) &&
            $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output transfer changed while stalled");

    // An accepted point keeps the input closed on the next cycle.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_EVAL) |=>
            !s_axis_tready)
        else $error("input ready right after a point was accepted");

    // The end of a batch only comes with the last row of a point.
    a_batch_last: assert property (@(posedge clk)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("batch end without last row");

    // During reset nothing is offered and the input is open.
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid && s_axis_tready)
        else $error("bad port state during reset");

endmodule

bind chebyshev_interpolation_weights_unit cciw_checker u_cciw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: dv/node_weight_checker.sv
module node_weight_checker
    import cciw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // coef_row, coef_col, coef_value, point_x, point_y, point_z
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // node_index, weight_x, weight_y, weight_z
    input  logic [M_DATA_W-1:0]   m_axis_tdata,
    // batch_end
    input  logic                  m_axis_tuser,
    input  logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int TABLE_DIM = 16;
    localparam int FRAC_BITS = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [IDX_W-1:0]        node;
        logic signed [OUT_W-1:0] wx;
        logic signed [OUT_W-1:0] wy;
        logic signed [OUT_W-1:0] wz;
        logic                    last;
        logic                    batch_end;
    } weight_row_t;

    logic signed [COEF_W-1:0] coef_mem [TABLE_DIM][TABLE_DIM];
    logic [CFG_W-1:0]         node_count;
    weight_row_t              expected_rows [$];
    int                       err_count;

    // Divide by 2^FRAC_BITS, rounding to nearest with ties toward +infinity.
    function automatic longint round_frac(longint p);
        return (p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int active_nodes(logic [CFG_W-1:0] count);
        if (count == 0)
            return 1;
        if (count > TABLE_DIM)
            return TABLE_DIM;
        return int'(count);
    endfunction

    // Clenshaw sum of one table row at coordinate x, scaled by 2/n.
    function automatic logic signed [OUT_W-1:0] clenshaw_weight(int n, longint x, int row);
        longint d0;
        longint d1;
        longint prev;
        longint r;
        longint mag;
        longint q;
        int     j;
        d0 = 0;
        d1 = 0;
        for (j = n - 1; j > 0; j--)
        begin
            prev = d0;
            d0 = clamp(round_frac(2 * x * d0) - d1 + longint'(coef_mem[row][j]),
                       longint'(ACC_MIN), longint'(ACC_MAX));
            d1 = prev;
        end
        r = round_frac(x * d0) - d1 + (longint'(coef_mem[row][0]) >>> 1);
        mag = (r < 0) ? -r : r;
        q = (2 * mag + longint'(n / 2)) / longint'(n);
        if (r < 0)
            q = -q;
        return OUT_W'(clamp(q, longint'(OUT_MIN), longint'(OUT_MAX)));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        weight_row_t got;
        weight_row_t want;
        int          n;
        int          m;
        longint      px;
        longint      py;
        longint      pz;
        if (!rst_n)
        begin
            node_count = NODES_RESET;
            expected_rows.delete();
            err_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                node_count = cfg_wdata;

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == REQ_LOAD)
                begin
                    coef_mem[s_axis_tdata[ROW_LSB +: IDX_W]][s_axis_tdata[COL_LSB +: IDX_W]] =
                        s_axis_tdata[COEF_LSB +: COEF_W];
                end
                else
                begin
                    n = active_nodes(node_count);
                    px = longint'($signed(s_axis_tdata[PX_LSB +: COORD_W]));
                    py = longint'($signed(s_axis_tdata[PY_LSB +: COORD_W]));
                    pz = longint'($signed(s_axis_tdata[PZ_LSB +: COORD_W]));
                    for (m = 0; m < n; m++)
                    begin
                        want.node = IDX_W'(m);
                        want.wx = clenshaw_weight(n, px, m);
                        want.wy = clenshaw_weight(n, py, m);
                        want.wz = clenshaw_weight(n, pz, m);
                        want.last = (m == n - 1);
                        want.batch_end = want.last & s_axis_tlast;
                        expected_rows.push_back(want);
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.node = m_axis_tdata[IDX_W-1:0];
                got.wx = m_axis_tdata[IDX_W +: OUT_W];
                got.wy = m_axis_tdata[IDX_W + OUT_W +: OUT_W];
                got.wz = m_axis_tdata[IDX_W + 2 * OUT_W +: OUT_W];
                got.last = m_axis_tlast;
                got.batch_end = m_axis_tuser;
                if (expected_rows.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("Unexpected output transfer: node %0d x %0d y %0d z %0d",
                                 got.node, got.wx, got.wy, got.wz);
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (got.node !== want.node || got.wx !== want.wx || got.wy !== want.wy ||
                        got.wz !== want.wz || got.last !== want.last ||
                        got.batch_end !== want.batch_end)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                        begin
                            $display("Weight mismatch, expected: node %0d x %0d y %0d z %0d last %0b end %0b",
                                     want.node, want.wx, want.wy, want.wz, want.last,
                                     want.batch_end);
                            $display("                 actual:   node %0d x %0d y %0d z %0d last %0b end %0b",
                                     got.node, got.wx, got.wy, got.wz, got.last, got.batch_end);
                        end
                    end
                end
            end

            mismatches <= err_count;
            outstanding <= expected_rows.size();
        end
    end

endmodule

// File: dv/tb_top.sv
module tb_top;

    import cciw_pkg::*;

    localparam int TABLE_DIM = 16;
    localparam int CLOCK_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 2000;
    localparam int IDLE_SETTLE = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;

    int mismatch_count;
    int rows_outstanding;
    int cycle_count;
    bit quiet;
    bit loaded [TABLE_DIM][TABLE_DIM];

    logic [CFG_W-1:0] node_settings [11] = '{5'd2, 5'd3, 5'd1, 5'd4, 5'd6, 5'd8, 5'd31,
                                             5'd7, 5'd5, 5'd16, 5'd3};

    chebyshev_interpolation_weights_unit uut (.*);

    node_weight_checker checker_i (
        .mismatches(mismatch_count),
        .outstanding(rows_outstanding),
        .*
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int active_nodes(logic [CFG_W-1:0] count);
        if (count == 0)
            return 1;
        if (count > TABLE_DIM)
            return TABLE_DIM;
        return int'(count);
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_request(logic [IDX_W-1:0] row,
                                                         logic [IDX_W-1:0] col,
                                                         logic [COEF_W-1:0] coef,
                                                         logic [COORD_W-1:0] px,
                                                         logic [COORD_W-1:0] py,
                                                         logic [COORD_W-1:0] pz);
        logic [S_DATA_W-1:0] data;
        data = '0;
        data[ROW_LSB +: IDX_W] = row;
        data[COL_LSB +: IDX_W] = col;
        data[COEF_LSB +: COEF_W] = coef;
        data[PX_LSB +: COORD_W] = px;
        data[PY_LSB +: COORD_W] = py;
        data[PZ_LSB +: COORD_W] = pz;
        return data;
    endfunction

    // Half the values within +/-1.0, the rest the extremes and full-range values.
    function automatic logic [COORD_W-1:0] pick_value();
        int v;
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            1, 2, 3, 4:
            begin
                v = $urandom_range(0, 131072);
                return COORD_W'(v - 65536);
            end
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic push_item(logic req, logic [S_DATA_W-1:0] data, logic fin);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= req;
        s_axis_tlast <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic load_coef(int row, int col, logic [COEF_W-1:0] value, logic fin);
        push_item(REQ_LOAD, pack_request(IDX_W'(row), IDX_W'(col), value, COORD_W'($urandom),
                                         COORD_W'($urandom), COORD_W'($urandom)), fin);
        loaded[row][col] = 1'b1;
    endtask

    task automatic eval_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [COORD_W-1:0] pz, logic fin);
        push_item(REQ_EVAL, pack_request(IDX_W'($urandom), IDX_W'($urandom),
                                         COEF_W'($urandom), px, py, pz), fin);
    endtask

    // Every coefficient that an evaluation at n nodes reads must be written first.
    task automatic fill_rows(int n);
        int r;
        int c;
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                if (!loaded[r][c])
                    load_coef(r, c, pick_value(), $urandom_range(0, 1));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (rows_outstanding != 0)
            @(posedge clk);
    endtask

    // The node count may change only while the block is idle.
    task automatic set_node_count(logic [CFG_W-1:0] value);
        wait_drained();
        repeat (IDLE_SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(int n, int count);
        int k;
        int row;
        int col;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                row = $urandom_range(0, 1) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
                col = $urandom_range(0, 1) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
                load_coef(row, col, pick_value(), $urandom_range(0, 1));
            end
            else
            begin
                eval_point(pick_value(), pick_value(), pick_value(), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // The receiver alternates random bursts of ready and stall, and is always ready while quiet.
    initial
    begin
        forever
        begin
            if (quiet)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CLOCK_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int p;
        int n;
        quiet = 1'b0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= REQ_LOAD;
        s_axis_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The node count after reset is five.
        fill_rows(5);
        eval_point(18'h1FFFF, 18'h20000, 18'h00000, 1'b0);
        eval_point(18'h20000, 18'h10000, 18'h30000, 1'b1);
        eval_point(18'h00000, 18'h1FFFF, 18'h20000, 1'b0);

        // A count of zero behaves as one node.
        set_node_count(5'd0);
        load_coef(0, 0, 18'h1FFFF, 1'b1);
        eval_point(18'h1FFFF, 18'h20000, 18'h00001, 1'b1);
        load_coef(0, 0, 18'h20000, 1'b0);
        eval_point(18'h3FFFF, 18'h10000, 18'h30000, 1'b0);

        set_node_count(5'd2);
        load_coef(0, 1, 18'h1FFFF, 1'b1);
        load_coef(1, 0, 18'h20000, 1'b0);
        load_coef(1, 1, 18'h00000, 1'b1);
        eval_point(18'h1FFFF, 18'h20000, 18'h10000, 1'b1);
        eval_point(18'h00000, 18'h30000, 18'h1FFFF, 1'b0);

        for (p = 0; p < $size(node_settings); p++)
        begin
            n = active_nodes(node_settings[p]);
            if (p == $size(node_settings) - 1)
                quiet = 1'b1;
            set_node_count(node_settings[p]);
            fill_rows(n);
            random_items(n, (n == TABLE_DIM) ? 8 : 16);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && rows_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: chebyshev_interpolation_weights_unit.f
rtl/cciw_pkg.sv
rtl/cciw_lane.sv
rtl/cciw_seq.sv
rtl/chebyshev_interpolation_weights_unit.sv
rtl/cciw_checker.sv
dv/node_weight_checker.sv
dv/tb_top.sv
